FILE: hdl/monitor_command_parser_assert.svh
// Assertion macros shared by the monitor command parser checker.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef MONITOR_COMMAND_PARSER_ASSERT_SVH
`define MONITOR_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mcp_pkg.sv
// Package for the monitor command parser: character codes, result kinds
// and the hex digit decoder. No dependencies.
package mcp_pkg;

    localparam logic [7:0] CHAR_SKIP    = 8'hFF;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_WRITE_S = 8'h53;
    localparam logic [7:0] CHAR_WRITE_Y = 8'h59;
    localparam logic [7:0] CHAR_IDLE    = 8'h7A;   // 'z'
    localparam logic [3:0] DIGIT_TEN    = 4'hA;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
    } t_hex;

    // Decode one ASCII hex digit, either case.
    function automatic t_hex hex_decode(input logic [7:0] ch);
        t_hex h;
        h.is_hex = 1'b0;
        h.nibble = 4'h0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.is_hex = 1'b1;
            h.nibble = ch[3:0];
        end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
            h.is_hex = 1'b1;
            h.nibble = ch[3:0] - 4'h1 + DIGIT_TEN;
        end
        return h;
    endfunction

endpackage

FILE: hdl/monitor_command_parser.sv
// Monitor command parser top level: byte stream in, command records and
// write payload bytes out. Depends on mcp_pkg.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+-----------------------------------
//  rx       | in  | i_rx_valid / o_rx_ready   | i_rx_byte
//  res      | out | o_res_valid / i_res_ready | o_kind, o_command_code, o_address,
//           |     |                           | o_value, o_data_byte, o_last
//
// One byte per cycle while o_rx_ready is high; a result shows in the cycle after its byte is accepted.
// The parse state is updated in the accepting cycle, the result lands in an
// output register, so the only stall source is that register being full
// while the sink holds i_res_ready low.
// Reset (i_rst_n low, synchronous) empties the output register and returns
// the letter to 'z' and all counters and numbers to zero.
module monitor_command_parser
    import mcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_kind,
    output logic [7:0]  o_command_code,
    output logic [31:0] o_address,
    output logic [31:0] o_value,
    output logic [7:0]  o_data_byte,
    output logic        o_last
);

    // Parse state
    logic [7:0]  r_letter,  n_letter;
    logic [31:0] r_number,  n_number;
    logic [31:0] r_addr,    n_addr;
    logic [31:0] r_remain,  n_remain;
    logic [31:0] r_offset,  n_offset;

    // Result register
    logic        r_res_valid;
    logic        r_kind,    n_kind;
    logic [7:0]  r_code,    n_code;
    logic [31:0] r_res_addr, n_res_addr;
    logic [31:0] r_value,   n_value;
    logic [7:0]  r_data,    n_data;
    logic        r_last,    n_last;
    logic        n_emit;

    logic        accept;
    logic        in_payload;
    t_hex        hex;

    // Output register frees up in the same cycle it is drained.
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign accept     = i_rx_valid && o_rx_ready;
    assign in_payload = (r_remain != 32'd0);
    assign hex        = hex_decode(i_rx_byte);

    always_comb begin
        n_letter   = r_letter;
        n_number   = r_number;
        n_addr     = r_addr;
        n_remain   = r_remain;
        n_offset   = r_offset;
        n_emit     = 1'b0;
        n_kind     = KIND_CMD;
        n_code     = r_letter;
        n_res_addr = r_addr;
        n_value    = r_number;
        n_data     = 8'h00;
        n_last     = 1'b0;

        if (in_payload) begin
            // Raw payload byte: no parsing at all, 0xFF included.
            n_emit     = 1'b1;
            n_kind     = KIND_DATA;
            n_code     = 8'h00;
            n_res_addr = r_addr + r_offset;
            n_value    = 32'd0;
            n_data     = i_rx_byte;
            n_last     = (r_remain == 32'd1);
            n_remain   = r_remain - 32'd1;
            n_offset   = r_offset + 32'd1;
        end else if (i_rx_byte == CHAR_SKIP) begin
            // filler byte, dropped
        end else if (i_rx_byte == CHAR_HASH) begin
            n_emit = 1'b1;
            if (r_letter == CHAR_WRITE_S || r_letter == CHAR_WRITE_Y) begin
                n_remain = r_number;
                n_offset = 32'd0;
            end
            n_letter = CHAR_IDLE;
            n_number = 32'd0;
        end else if (hex.is_hex) begin
            n_number = {r_number[27:0], hex.nibble};
        end else if (i_rx_byte == CHAR_COMMA) begin
            n_addr   = r_number;
            n_number = 32'd0;
        end else begin
            n_letter = i_rx_byte;
            n_number = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letter    <= CHAR_IDLE;
            r_number    <= 32'd0;
            r_addr      <= 32'd0;
            r_remain    <= 32'd0;
            r_offset    <= 32'd0;
            r_res_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_letter <= n_letter;
                r_number <= n_number;
                r_addr   <= n_addr;
                r_remain <= n_remain;
                r_offset <= n_offset;
            end
            if (accept && n_emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_kind     <= n_kind;
            r_code     <= n_code;
            r_res_addr <= n_res_addr;
            r_value    <= n_value;
            r_data     <= n_data;
            r_last     <= n_last;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_kind         = r_kind;
    assign o_command_code = r_code;
    assign o_address      = r_res_addr;
    assign o_value        = r_value;
    assign o_data_byte    = r_data;
    assign o_last         = r_last;

endmodule

FILE: hdl/mcp_checker.sv
// Port-level checker for the monitor command parser, bound to the top level.
// Depends on mcp_pkg and monitor_command_parser_assert.svh.
`include "monitor_command_parser_assert.svh"

module mcp_checker
    import mcp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        o_rx_ready,
    input logic [7:0]  i_rx_byte,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic        o_kind,
    input logic [7:0]  o_command_code,
    input logic [31:0] o_address,
    input logic [31:0] o_value,
    input logic [7:0]  o_data_byte,
    input logic        o_last
);

    // stalled result holds
    `MCP_ASSERT_NEXT(a_res_hold, o_res_valid && !i_res_ready,
        o_res_valid && $stable(o_kind) && $stable(o_address) && $stable(o_data_byte),
        "stalled result changed")

    // empty output register never blocks input
    `MCP_ASSERT_NOW(a_ready_when_empty, !o_res_valid, o_rx_ready,
        "input stalled with empty output")

    `MCP_ASSERT_NOW(a_cmd_fields, o_res_valid && o_kind == KIND_CMD,
        o_data_byte == 8'h00 && !o_last, "command record carries payload fields")

    `MCP_ASSERT_NOW(a_data_fields, o_res_valid && o_kind == KIND_DATA,
        o_command_code == 8'h00 && o_value == 32'd0, "payload byte carries command fields")

    // a payload run continues until its last byte
    `MCP_ASSERT_NOW(a_run_continues,
        (o_res_valid && i_res_ready && o_kind == KIND_DATA && !o_last) ##1 o_res_valid,
        o_kind == KIND_DATA, "payload run broken before last byte")

endmodule

bind monitor_command_parser mcp_checker u_mcp_checker (.*);
